@@ rtl/cfcp_pkg.sv @@
// Shared constants, codes and the CRC-16 byte update for the framed command parser.
package cfcp_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 64;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned CRC_W    = 16;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 3;

    localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_FRAME_BYTES);

    // Byte positions inside a frame
    localparam logic [POS_W-1:0] POS_HUNT    = 8'd0;
    localparam logic [POS_W-1:0] POS_SECOND  = 8'd1;
    localparam logic [POS_W-1:0] POS_VERSION = 8'd2;
    localparam logic [POS_W-1:0] POS_TYPE    = 8'd3;
    localparam logic [POS_W-1:0] POS_HEADER  = 8'd5;
    localparam logic [POS_W-1:0] POS_LENGTH  = 8'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = 8'd6;

    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_CRC      = 3'd1,
        ST_VERSION  = 3'd2,
        ST_TYPE     = 3'd3,
        ST_SIZE     = 3'd4,
        ST_TOO_LONG = 3'd5,
        ST_OVERFLOW = 3'd6
    } status_t;

    // Register indexes on the configuration port
    localparam int unsigned REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_START_FIRST  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_START_SECOND = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_VERSION      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_TYPE         = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_CMD_BYTES    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT        = 3'd5;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned APB_W  = 32;

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ rtl/crc_framed_command_parser.sv @@
// Framed command parser: start-marker hunt, header/payload capture and CRC-16 check.
//
// Takes one received byte per word on the s_ side and reports one result word per
// finished frame on the m_ side. A frame is: two start marker bytes, version, type,
// sequence, length, <length> payload bytes, then the CRC-16 (reflected, init 0xFFFF,
// poly 0xA001) low byte first, computed over version through the last payload byte.
// A repeated first marker byte while waiting for the second keeps the hunt armed.
// Each result carries the status in m_tuser and the first payload byte plus
// payload bytes 1..4 (little-endian, signed) in m_tdata. A declared length above
// payload_limit ends the frame at once (status 5); a byte at position
// MAX_FRAME_BYTES is dropped and ends the frame (status 6); both report zero data.
// Throughput: one byte per clock. Every byte is parsed in the cycle it is taken,
// with the CRC byte update and position counter feeding the frame state and the
// output register directly; s_tready drops only while a result sits in the output
// register and m_tready is low. Results are registered when the closing byte is taken.
// Registers (APB, byte address 4*i): 0 start_byte_first, 1 start_byte_second,
// 2 expected_version, 3 command_type_code, 4 command_payload_bytes,
// 5 payload_limit. Write them only while the parser is idle.
module crc_framed_command_parser
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cfcp_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte

    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [39:0]                   m_tdata,   // [7:0] command_code, [39:8] command_value
    output logic [cfcp_pkg::STATUS_W-1:0] m_tuser,   // [2:0] frame_status

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cfcp_pkg::ADDR_W-1:0]   paddr,
    input  logic [cfcp_pkg::APB_W-1:0]    pwdata,
    output logic [cfcp_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import cfcp_pkg::*;

    // Configuration registers
    logic [BYTE_W-1:0] start_first_reg, start_second_reg, exp_version_reg;
    logic [BYTE_W-1:0] cmd_type_reg, cmd_bytes_reg, limit_reg;

    // Frame state
    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic [CRC_W-1:0]   crc_reg,      crc_next;
    logic [BYTE_W-1:0]  version_reg,  version_next;
    logic [BYTE_W-1:0]  type_reg,     type_next;
    logic [BYTE_W-1:0]  length_reg,   length_next;
    logic [BYTE_W-1:0]  cmd_reg,      cmd_next;
    logic [VALUE_W-1:0] value_reg,    value_next;
    logic [BYTE_W-1:0]  crc_low_reg,  crc_low_next;

    // Output register
    logic               out_valid_reg;
    status_t            out_status_reg, out_status_next;
    logic [BYTE_W-1:0]  out_code_reg,   out_code_next;
    logic [VALUE_W-1:0] out_value_reg,  out_value_next;

    logic                  accept;
    logic                  emit;
    logic                  out_load;
    logic [BYTE_W-1:0]     rx;
    logic [BYTE_W-1:0]     len;
    logic [POS_W:0]        crc_lo_pos;     // position of the CRC low byte
    logic [POS_W-1:0]      pay_idx;
    logic [CRC_W-1:0]      crc_got;
    logic                  cfg_wr;
    logic [REG_IDX_W-1:0]  cfg_idx;

    assign pready   = 1'b1;
    assign cfg_idx  = paddr[ADDR_W-1:2];
    assign cfg_wr   = psel && penable && pwrite;

    // Output register frees up when drained this cycle
    assign out_load = !out_valid_reg || m_tready;
    assign s_tready = out_load;
    assign accept   = s_tvalid && s_tready;
    assign rx       = s_tdata;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_value_reg, out_code_reg};

    always_comb
    begin
        unique case (cfg_idx)
            REG_START_FIRST:  prdata = APB_W'(start_first_reg);
            REG_START_SECOND: prdata = APB_W'(start_second_reg);
            REG_VERSION:      prdata = APB_W'(exp_version_reg);
            REG_TYPE:         prdata = APB_W'(cmd_type_reg);
            REG_CMD_BYTES:    prdata = APB_W'(cmd_bytes_reg);
            REG_LIMIT:        prdata = APB_W'(limit_reg);
            default:          prdata = '0;
        endcase
    end

    // Byte parser
    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        version_next    = version_reg;
        type_next       = type_reg;
        length_next     = length_reg;
        cmd_next        = cmd_reg;
        value_next      = value_reg;
        crc_low_next    = crc_low_reg;
        emit            = 1'b0;
        out_status_next = ST_OK;
        out_code_next   = '0;
        out_value_next  = '0;

        len        = (pos_reg == POS_LENGTH) ? rx : length_reg;
        crc_lo_pos = {1'b0, len} + (POS_W+1)'(POS_PAYLOAD);
        pay_idx    = pos_reg - POS_PAYLOAD;
        crc_got    = {rx, crc_low_reg};

        if (pos_reg == POS_HUNT)
        begin
            if (rx == start_first_reg)
                pos_next = POS_SECOND;
        end
        else if (pos_reg == POS_SECOND)
        begin
            if (rx == start_second_reg)
                pos_next = POS_VERSION;
            else if (rx == start_first_reg)
                pos_next = POS_SECOND;
            else
                pos_next = POS_HUNT;
        end
        else if (pos_reg >= MAX_POS)
        begin
            // byte dropped
            emit            = 1'b1;
            out_status_next = ST_OVERFLOW;
            pos_next        = POS_HUNT;
        end
        else
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg < POS_HEADER)
            begin
                if (pos_reg == POS_VERSION)
                begin
                    version_next = rx;
                    crc_next     = crc_feed(CRC_INIT, rx);
                end
                else
                begin
                    if (pos_reg == POS_TYPE)
                        type_next = rx;
                    crc_next = crc_feed(crc_reg, rx);
                end
            end
            else
            begin
                if (pos_reg == POS_LENGTH)
                begin
                    length_next = rx;
                    cmd_next    = '0;
                    value_next  = '0;
                    crc_next    = crc_feed(crc_reg, rx);
                end

                if (len > limit_reg)
                begin
                    emit            = 1'b1;
                    out_status_next = ST_TOO_LONG;
                    pos_next        = POS_HUNT;
                end
                else if (pos_reg == POS_LENGTH)
                begin
                    // header done, payload follows
                end
                else if ({1'b0, pos_reg} < crc_lo_pos)
                begin
                    case (pay_idx)
                        8'd0:    cmd_next          = rx;
                        8'd1:    value_next[7:0]   = rx;
                        8'd2:    value_next[15:8]  = rx;
                        8'd3:    value_next[23:16] = rx;
                        8'd4:    value_next[31:24] = rx;
                        default: ; // CRC only
                    endcase
                    crc_next = crc_feed(crc_reg, rx);
                end
                else if ({1'b0, pos_reg} == crc_lo_pos)
                begin
                    crc_low_next = rx;
                end
                else
                begin
                    emit           = 1'b1;
                    pos_next       = POS_HUNT;
                    out_code_next  = cmd_reg;
                    out_value_next = value_reg;
                    if (crc_got != crc_reg)
                        out_status_next = ST_CRC;
                    else if (version_reg != exp_version_reg)
                        out_status_next = ST_VERSION;
                    else if (type_reg != cmd_type_reg)
                        out_status_next = ST_TYPE;
                    else if (length_reg != cmd_bytes_reg)
                        out_status_next = ST_SIZE;
                    else
                        out_status_next = ST_OK;
                end
            end
        end
    end

    // Control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_first_reg  <= 8'hA5;
            start_second_reg <= 8'h5A;
            exp_version_reg  <= 8'h01;
            cmd_type_reg     <= 8'h01;
            cmd_bytes_reg    <= 8'h05;
            limit_reg        <= 8'd56;
            pos_reg          <= POS_HUNT;
            crc_reg          <= CRC_INIT;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    REG_START_FIRST:  start_first_reg  <= pwdata[BYTE_W-1:0];
                    REG_START_SECOND: start_second_reg <= pwdata[BYTE_W-1:0];
                    REG_VERSION:      exp_version_reg  <= pwdata[BYTE_W-1:0];
                    REG_TYPE:         cmd_type_reg     <= pwdata[BYTE_W-1:0];
                    REG_CMD_BYTES:    cmd_bytes_reg    <= pwdata[BYTE_W-1:0];
                    REG_LIMIT:        limit_reg        <= pwdata[BYTE_W-1:0];
                    default:          ;
                endcase
            end
            if (accept)
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
            end
            if (out_load)
                out_valid_reg <= accept && emit;
        end
    end

    // Frame field and output data registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            version_reg <= version_next;
            type_reg    <= type_next;
            length_reg  <= length_next;
            cmd_reg     <= cmd_next;
            value_reg   <= value_next;
            crc_low_reg <= crc_low_next;
        end
        if (accept && emit)
        begin
            out_status_reg <= out_status_next;
            out_code_reg   <= out_code_next;
            out_value_reg  <= out_value_next;
        end
    end

endmodule

@@ bench/tb.sv @@
// Self-checking bench for the framed command parser: random framed byte streams vs. a predictor.
module tb;
    import cfcp_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES = 300;    // long receiver back-off
    localparam int RX_TARGET   = 1250;   // rx words to send before wrapping up

    typedef struct {
        status_t     status;
        logic [7:0]  code;
        logic [31:0] value;
    } frame_report_t;

    // Tracks the parser byte by byte and queues the report each finished frame must give.
    class frame_checker;
        logic [7:0]    regs [6];
        logic [7:0]    pos;
        logic [7:0]    ver_q;
        logic [7:0]    type_q;
        logic [7:0]    len_q;
        logic [7:0]    code_q;
        logic [7:0]    crc_lo_q;
        logic [15:0]   crc_q;
        logic [31:0]   value_q;
        frame_report_t reports_due [$];
        int            fails;

        function new();
            regs[REG_START_FIRST]  = 8'hA5;
            regs[REG_START_SECOND] = 8'h5A;
            regs[REG_VERSION]      = 8'h01;
            regs[REG_TYPE]         = 8'h01;
            regs[REG_CMD_BYTES]    = 8'h05;
            regs[REG_LIMIT]        = 8'd56;
            pos      = POS_HUNT;
            crc_q    = 16'hFFFF;
            ver_q    = '0;
            type_q   = '0;
            len_q    = '0;
            code_q   = '0;
            crc_lo_q = '0;
            value_q  = '0;
            fails    = 0;
        endfunction

        // CRC-16/MODBUS, one bit at a time, LSB first
        static function logic [15:0] crc16_step(logic [15:0] c, logic [7:0] d);
            logic fb;
            int   i;
            for (i = 0; i < 8; i++)
            begin
                fb = c[0] ^ d[i];
                c  = c >> 1;
                if (fb)
                    c = c ^ 16'hA001;
            end
            return c;
        endfunction

        function void close_frame(status_t st, logic [7:0] code, logic [31:0] value);
            frame_report_t r;
            r.status = st;
            r.code   = code;
            r.value  = value;
            reports_due.push_back(r);
            pos = POS_HUNT;
        endfunction

        function void take_rx_byte(logic [7:0] b);
            int      idx;
            int      plen;
            status_t st;
            idx = pos;
            // marker hunt; a repeated first marker keeps us armed
            if (idx == int'(POS_HUNT))
            begin
                if (b == regs[REG_START_FIRST])
                    pos = POS_SECOND;
                return;
            end
            if (idx == int'(POS_SECOND))
            begin
                if (b == regs[REG_START_SECOND])
                    pos = POS_VERSION;
                else if (b == regs[REG_START_FIRST])
                    pos = POS_SECOND;
                else
                    pos = POS_HUNT;
                return;
            end
            // byte past the buffer is dropped
            if (idx >= MAX_FRAME_BYTES)
            begin
                close_frame(ST_OVERFLOW, 8'h00, 32'h0);
                return;
            end
            pos = 8'(idx + 1);
            if (idx < int'(POS_HEADER))
            begin
                if (idx == int'(POS_VERSION))
                begin
                    ver_q = b;
                    crc_q = 16'hFFFF;
                end
                else if (idx == int'(POS_TYPE))
                    type_q = b;
                crc_q = crc16_step(crc_q, b);
                return;
            end
            if (idx == int'(POS_LENGTH))
            begin
                len_q   = b;
                code_q  = 8'h00;
                value_q = 32'h0;
                crc_q   = crc16_step(crc_q, b);
            end
            plen = len_q;
            // limit is rechecked on every byte from the length on
            if (len_q > regs[REG_LIMIT])
            begin
                close_frame(ST_TOO_LONG, 8'h00, 32'h0);
                return;
            end
            if (idx == int'(POS_LENGTH))
                return;
            if (idx < int'(POS_PAYLOAD) + plen)
            begin
                if (idx == int'(POS_PAYLOAD))
                    code_q = b;
                else if (idx <= int'(POS_PAYLOAD) + 4)
                    value_q[8*(idx-int'(POS_PAYLOAD)-1) +: 8] = b;
                crc_q = crc16_step(crc_q, b);
                return;
            end
            if (idx == int'(POS_PAYLOAD) + plen)
            begin
                crc_lo_q = b;
                return;
            end
            if ({b, crc_lo_q} != crc_q)
                st = ST_CRC;
            else if (ver_q != regs[REG_VERSION])
                st = ST_VERSION;
            else if (type_q != regs[REG_TYPE])
                st = ST_TYPE;
            else if (len_q != regs[REG_CMD_BYTES])
                st = ST_SIZE;
            else
                st = ST_OK;
            close_frame(st, code_q, value_q);
        endfunction

        function void check_report(logic [2:0] st, logic [7:0] code, logic [31:0] value);
            frame_report_t e;
            if (reports_due.size() == 0)
            begin
                $error("report word with no frame pending: status %0d", st);
                fails++;
                return;
            end
            e = reports_due.pop_front();
            if (st !== e.status)
            begin
                $error("frame_status: expected %0d, got %0d", e.status, st);
                fails++;
            end
            if (code !== e.code)
            begin
                $error("command_code: expected 0x%02h, got 0x%02h", e.code, code);
                fails++;
            end
            if (value !== e.value)
            begin
                $error("command_value: expected %0d, got %0d",
                       $signed(e.value), $signed(value));
                fails++;
            end
        endfunction

        function int pending();
            return reports_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [39:0]         m_tdata;     // [7:0] command_code, [39:8] command_value
    logic [2:0]          m_tuser;     // [2:0] frame_status
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    frame_checker sb = new();

    int   rx_count;
    int   quiet_cycles;
    int   hold_cycles_req;
    bit   tx_idle_on;
    bit   rx_idle_on;
    logic [7:0] payload_q [$];   // preset payload for the next frame, rest is random

    crc_framed_command_parser dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Handshake monitor and watchdog; values read here are the pre-edge ones.
    initial
    begin
        rx_count     = 0;
        quiet_cycles = 0;
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_report(m_tuser, m_tdata[7:0], m_tdata[39:8]);
        if (s_tvalid && s_tready)
        begin
            sb.take_rx_byte(s_tdata);
            rx_count++;
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Report side: random stall before each word, or a long back-off on request.
    initial
    begin
        hold_cycles_req = 0;
        rx_idle_on      = 1'b1;
        forever
        begin
            if (hold_cycles_req != 0)
            begin
                m_tready <= 1'b0;
                repeat (hold_cycles_req) @(posedge clk);
                hold_cycles_req = 0;
            end
            else
            begin
                int stall;
                stall = rx_idle_on ? $urandom_range(0, 13) : 0;
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                m_tready <= 1'b1;
                do @(posedge clk); while (!m_tvalid && hold_cycles_req == 0);
            end
        end
    end

    // One rx word; tvalid stays up afterwards so back-to-back words need no gap.
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
    endtask

    // Builds a frame with the current markers; cut < 0 sends all of it.
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] typ,
                              input logic [7:0] len, input bit bad_crc, input int cut);
        logic [7:0]  fbytes [$];
        logic [15:0] crc;
        int          i;
        fbytes.push_back(sb.regs[REG_START_FIRST]);
        fbytes.push_back(sb.regs[REG_START_SECOND]);
        fbytes.push_back(ver);
        fbytes.push_back(typ);
        fbytes.push_back(8'($urandom_range(0, 255)));   // sequence, unchecked
        fbytes.push_back(len);
        for (i = 0; i < int'(len); i++)
            fbytes.push_back(i < payload_q.size() ? payload_q[i] : 8'($urandom_range(0, 255)));
        payload_q.delete();
        crc = 16'hFFFF;
        for (i = 2; i < fbytes.size(); i++)
            crc = frame_checker::crc16_step(crc, fbytes[i]);
        if (bad_crc)
            crc ^= 16'(1 << $urandom_range(0, 15));
        fbytes.push_back(crc[7:0]);
        fbytes.push_back(crc[15:8]);
        if (cut < 0 || cut > fbytes.size())
            cut = fbytes.size();
        for (i = 0; i < cut; i++)
            send_rx(fbytes[i]);
    endtask

    // Mostly well-formed frames with random faults, plus noise and broken frames.
    task automatic random_frame();
        int         kind;
        int         lim;
        logic [7:0] ver;
        logic [7:0] typ;
        logic [7:0] len;
        logic [7:0] cmd;
        bit         bad_crc;
        int         cut;
        ver     = sb.regs[REG_VERSION];
        typ     = sb.regs[REG_TYPE];
        cmd     = sb.regs[REG_CMD_BYTES];
        lim     = sb.regs[REG_LIMIT];
        len     = cmd;
        bad_crc = 1'b0;
        cut     = -1;
        // keep long command sizes rare so frames stay short
        if (cmd > 12 && $urandom_range(0, 7) != 0)
            len = 8'($urandom_range(0, 8));
        kind = $urandom_range(0, 15);
        if (kind == 11 && lim >= 57)
            len = 8'($urandom_range(57, lim < 70 ? lim : 70));   // runs into overflow
        else if (kind >= 9 && kind <= 11 && lim < 255)
        begin
            len = 8'($urandom_range(lim + 1, 255));
            cut = 6 + $urandom_range(0, 2);
        end
        else if (kind == 12 || kind == 13)
        begin
            repeat ($urandom_range(1, 6)) send_rx(8'($urandom_range(0, 255)));
            return;
        end
        else if (kind == 14)
        begin
            // first marker followed by anything
            send_rx(sb.regs[REG_START_FIRST]);
            send_rx(8'($urandom_range(0, 255)));
            return;
        end
        else if (kind == 15)
            cut = $urandom_range(1, 10);
        if ($urandom_range(0, 5) == 0)
            bad_crc = 1'b1;
        if ($urandom_range(0, 5) == 0)
            ver ^= 8'($urandom_range(1, 255));
        if ($urandom_range(0, 5) == 0)
            typ ^= 8'($urandom_range(1, 255));
        if (kind <= 8 && $urandom_range(0, 5) == 0)
            len = 8'($urandom_range(0, 8));
        send_frame(ver, typ, len, bad_crc, cut);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.regs[idx] = val;
        @(posedge clk);
    endtask

    // Register sets: a few fixed ones with the extremes, then random changes.
    task automatic program_phase(input int phase);
        logic [7:0] v [6];
        int         i;
        // order: first marker, second marker, version, type, command size, limit
        case (phase)
            0: v = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF};
            1: v = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h08, 8'h00};
            2: v = '{8'hA5, 8'h5A, 8'h01, 8'h01, 8'h05, 8'd56};
            3: v = '{8'h7E, 8'h7E, 8'h02, 8'h80, 8'h04, 8'd60};
            4: v = '{8'h3C, 8'hC3, 8'h55, 8'hAA, 8'hFF, 8'hFF};
            default:
            begin
                v[REG_START_FIRST]  = 8'($urandom_range(0, 255));
                v[REG_START_SECOND] = 8'($urandom_range(0, 255));
                v[REG_VERSION]      = 8'($urandom_range(0, 255));
                v[REG_TYPE]         = 8'($urandom_range(0, 255));
                v[REG_CMD_BYTES]    = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                                  : 8'($urandom_range(0, 8));
                v[REG_LIMIT]        = ($urandom_range(0, 3) == 0)
                                      ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(int'(v[REG_CMD_BYTES]), 70));
            end
        endcase
        for (i = 0; i < 6; i++)
            if (phase < 5 || $urandom_range(0, 1) == 1)
                write_reg(REG_IDX_W'(i), v[i]);
    endtask

    // Stop sending and let every outstanding report come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (3) @(posedge clk);
    endtask

    initial
    begin
        int phase;
        int wait_cycles;
        rst_n      <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= 8'h00;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        tx_idle_on = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset registers: noise, repeated first marker, extreme payload
        // (value is the most negative one), empty payload, declared length too long.
        send_rx(8'h00);
        send_rx(8'hA5);
        payload_q = '{8'hFF, 8'h00, 8'h00, 8'h00, 8'h80};
        send_frame(8'h01, 8'h01, 8'h05, 1'b0, -1);
        send_frame(8'h01, 8'h01, 8'h00, 1'b0, -1);
        send_frame(8'h01, 8'h01, 8'hFF, 1'b0, 6);

        phase = 0;
        while (rx_count < RX_TARGET)
        begin
            wait_drained();
            program_phase(phase);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 2 || phase == 7)
            begin
                // receiver backs off while words keep coming: output fills, input stalls
                tx_idle_on      = 1'b0;
                hold_cycles_req = HOLD_CYCLES;
            end
            repeat ($urandom_range(6, 14)) random_frame();
            // sometimes leave a frame half done across the register change
            if ($urandom_range(0, 3) == 0)
                send_frame(sb.regs[REG_VERSION], sb.regs[REG_TYPE], sb.regs[REG_CMD_BYTES],
                           1'b0, 6 + $urandom_range(0, 3));
            phase++;
        end

        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 1000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (4) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d frame reports never arrived", sb.pending());
            sb.fails++;
        end
        if (sb.fails == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
